[sv/sorted_int_set_insert_report_macros.svh]
// ============================================================================
// Assertion macros for the sorted integer set
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ============================================================================
`ifndef SORTED_INT_SET_INSERT_REPORT_MACROS_SVH
`define SORTED_INT_SET_INSERT_REPORT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SISIR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SISIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SISIR_ASSERT_NOW(lbl, ante, cons, msg)
`define SISIR_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[sv/sisir_pkg.sv]
// ============================================================================
// sisir_pkg
// Shared types and codes of the sorted integer set.
// ============================================================================
package sisir_pkg;

    // Default number of cells in the chain.
    localparam int DEF_CAPACITY = 64;

    // Field widths fixed by the interface.
    localparam int VAL_W    = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 3;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_ELEMENT  = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_REPORT
    } state_t;

    // Per-cycle commands broadcast to every cell.
    typedef struct packed {
        logic ins_en;
        logic rot_en;
    } cell_ctrl_t;

endpackage

[sv/sisir_in_if.sv]
// ============================================================================
// sisir_in_if
// Input channel: command and value words with valid/ready handshake.
// ============================================================================
interface sisir_in_if
    import sisir_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

[sv/sisir_out_if.sv]
// ============================================================================
// sisir_out_if
// Result channel: element, count, status and last with valid/ready handshake.
// ============================================================================
interface sisir_out_if
    import sisir_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] element;
    logic [COUNT_W-1:0]      count;
    logic [STATUS_W-1:0]     status;
    logic                    last;

    modport source (output valid, output element, output count, output status,
                    output last, input ready);
    modport sink   (input valid, input element, input count, input status,
                    input last, output ready);
endinterface

[sv/sisir_cell.sv]
// ============================================================================
// sisir_cell
// One slot of the sorted chain: holds a value, compares it with the key and
// takes the key or a neighbour's value on an insert shift or a report rotation.
// ============================================================================
module sisir_cell
    import sisir_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
)
(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    input  logic signed [VAL_W-1:0] key,
    input  logic [CNT_W-1:0]        count,
    input  logic signed [VAL_W-1:0] prev_val,
    input  logic                    prev_gt,
    input  logic signed [VAL_W-1:0] next_val,
    input  logic signed [VAL_W-1:0] head_val,
    output logic signed [VAL_W-1:0] val,
    output logic                    gt,
    output logic                    eq
);

    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;
    logic                    occ;
    logic                    tail;

    // The cell is occupied when its index lies below the count.
    assign occ  = (CNT_W'(INDEX) < count);
    assign tail = (CNT_W'(INDEX + 1) == count);

    // An empty cell counts as greater than any key, so the chain stays ordered.
    assign gt  = !occ || (val_reg > key);
    assign eq  = occ && (val_reg == key);
    assign val = val_reg;

    // Insert shifts the greater part up by one; report rotates towards cell 0.
    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins_en && gt)
        begin
            val_next = prev_gt ? prev_val : key;
        end
        else if (ctrl.rot_en)
        begin
            val_next = tail ? head_val : next_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

[sv/sorted_int_set_insert_report.sv]
// ============================================================================
// sorted_int_set_insert_report
// Bounded sorted set of signed 32-bit integers kept in a chain of cells.
// ============================================================================
//
//  Channel   Role    Word
//  --------  ------  ------------------------------------------------------
//  in_ch     sink    command (insert / report), value
//  out_ch    source  element, count, status, last
//
//  An insert accepts the word in S_IDLE; in S_INSERT every cell then compares
//  with the key at once and the greater part of the chain shifts up.
//  A report rotates the chain one cell per cycle towards cell 0, which feeds
//  the result register, whenever that register is free to take a word.
//  A stalled result register holds the controller in place; rst_n clears the
//  count and the controller, with no clearing pass over the cells.
//
module sorted_int_set_insert_report
    import sisir_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic          clk,
    input  logic          rst_n,
    sisir_in_if.sink      in_ch,
    sisir_out_if.source   out_ch
);

`include "sorted_int_set_insert_report_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t                  state_reg,   state_next;
    logic [CNT_W-1:0]        count_reg,   count_next;
    logic [CNT_W-1:0]        rep_reg,     rep_next;
    logic signed [VAL_W-1:0] key_reg,     key_next;
    logic                    ovalid_reg,  ovalid_next;
    logic signed [VAL_W-1:0] elem_reg,    elem_next;
    logic [COUNT_W-1:0]      ocount_reg,  ocount_next;
    status_t                 status_reg,  status_next;
    logic                    last_reg,    last_next;

    cell_ctrl_t              ctrl;
    logic signed [VAL_W-1:0] val_w [CAPACITY];
    logic [CAPACITY-1:0]     gt_w;
    logic [CAPACITY-1:0]     eq_w;
    logic                    in_fire;
    logic                    out_free;
    logic                    dup;
    logic                    full;
    logic                    rep_last;

    // The chain of cells.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sisir_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .key      (key_reg),
            .count    (count_reg),
            .prev_val ((i == 0) ? key_reg : val_w[(i == 0) ? 0 : i - 1]),
            .prev_gt  ((i == 0) ? 1'b0 : gt_w[(i == 0) ? 0 : i - 1]),
            .next_val (val_w[(i == CAPACITY - 1) ? 0 : i + 1]),
            .head_val (val_w[0]),
            .val      (val_w[i]),
            .gt       (gt_w[i]),
            .eq       (eq_w[i])
        );
    end

    // Handshake and set status.
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !ovalid_reg || out_ch.ready;
    assign dup         = |eq_w;
    assign full        = (count_reg == CNT_W'(CAPACITY));
    assign rep_last    = ((rep_reg + CNT_W'(1)) == count_reg);

    // Next state, cell commands and result word.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rep_next    = rep_reg;
        key_next    = key_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        elem_next   = elem_reg;
        ocount_next = ocount_reg;
        status_next = status_reg;
        last_next   = last_reg;
        ctrl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    key_next   = in_ch.value;
                    rep_next   = '0;
                    state_next = (in_ch.command == CMD_REPORT) ? S_REPORT : S_INSERT;
                end
            end
            S_INSERT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    elem_next   = key_reg;
                    last_next   = 1'b1;
                    ocount_next = COUNT_W'(count_reg);
                    if (dup)
                    begin
                        status_next = ST_PRESENT;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.ins_en = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                        ocount_next = COUNT_W'(count_reg + CNT_W'(1));
                        status_next = ST_INSERTED;
                    end
                    state_next = S_IDLE;
                end
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ocount_next = COUNT_W'(count_reg);
                    if (count_reg == '0)
                    begin
                        elem_next   = '0;
                        status_next = ST_EMPTY;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        ctrl.rot_en = 1'b1;
                        elem_next   = val_w[0];
                        status_next = ST_ELEMENT;
                        last_next   = rep_last;
                        rep_next    = rep_reg + CNT_W'(1);
                        if (rep_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rep_reg    <= rep_next;
        key_reg    <= key_next;
        elem_reg   <= elem_next;
        ocount_reg <= ocount_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    // Result port.
    assign out_ch.valid   = ovalid_reg;
    assign out_ch.element = elem_reg;
    assign out_ch.count   = ocount_reg;
    assign out_ch.status  = status_reg;
    assign out_ch.last    = last_reg;

    // Checks.
    `SISIR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count beyond capacity")
    `SISIR_ASSERT_NXT(a_report_count, state_reg == S_REPORT, count_reg == $past(count_reg), "count moved during report")
    `SISIR_ASSERT_NXT(a_insert_grow, ctrl.ins_en, (status_reg == ST_INSERTED) && ovalid_reg, "insert gave no inserted word")
    `SISIR_ASSERT_NXT(a_report_entry, in_fire && (in_ch.command == CMD_REPORT), state_reg == S_REPORT, "report not started")

endmodule

[tb/sorted_set_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// sorted_set_checker
// Watches both channels of the sorted integer set. It keeps its own ascending
// copy of the held values and works out the result words that each accepted
// command word causes. It compares every accepted result word, field by
// field, with the oldest outstanding one.
// ============================================================================
module sorted_set_checker
    import sisir_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic  clk,
    input  logic  rst_n,
    sisir_in_if   in_ch,
    sisir_out_if  out_ch,
    output int    errors,
    output int    awaited,
    output int    results_checked,
    output int    dup_seen,
    output int    full_seen
);

    // One result word as the block should present it.
    typedef struct packed {
        logic signed [VAL_W-1:0] element;
        logic [COUNT_W-1:0]      count;
        status_t                 status;
        logic                    last;
    } set_result_t;

    // Held values in ascending signed order, and result words still to come.
    logic signed [VAL_W-1:0] held_vals[$];
    set_result_t             awaited_results[$];

    int mismatch_total;
    int checked_total;
    int dup_total;
    int full_total;

    function automatic set_result_t make_result(input logic signed [VAL_W-1:0] element,
                                                input int count, input status_t status,
                                                input logic last);
        set_result_t r;
        r.element = element;
        r.count   = COUNT_W'(count);
        r.status  = status;
        r.last    = last;
        return r;
    endfunction

    // Update the held set for one command word and queue its result words.
    task automatic apply_set_word(input logic cmd, input logic signed [VAL_W-1:0] v);
        int n;
        int pos;
        n = held_vals.size();
        if (cmd == CMD_REPORT)
        begin
            if (n == 0)
                awaited_results.push_back(make_result('0, 0, ST_EMPTY, 1'b1));
            else
                for (int i = 0; i < n; i++)
                    awaited_results.push_back(make_result(held_vals[i], n, ST_ELEMENT,
                                                          i == n - 1));
        end
        else
        begin
            pos = 0;
            while (pos < n && held_vals[pos] < v)
                pos++;
            if (pos < n && held_vals[pos] == v)
                awaited_results.push_back(make_result(v, n, ST_PRESENT, 1'b1));
            else if (n >= CAPACITY)
                awaited_results.push_back(make_result(v, n, ST_FULL, 1'b1));
            else
            begin
                held_vals.insert(pos, v);
                awaited_results.push_back(make_result(v, n + 1, ST_INSERTED, 1'b1));
            end
        end
    endtask

    // Compare one accepted result word with the oldest outstanding one.
    task automatic check_result_word();
        set_result_t want;
        set_result_t got;
        got = {out_ch.element, out_ch.count, out_ch.status, out_ch.last};
        if (awaited_results.size() == 0)
        begin
            mismatch_total++;
            if (mismatch_total <= 10)
            begin
                $display("%0t: result word with none outstanding:", $time);
                $display("    element %0d count %0d status %0d last %0b",
                         $signed(got.element), got.count, got.status, got.last);
            end
        end
        else
        begin
            want = awaited_results.pop_front();
            checked_total++;
            if (want.status == ST_PRESENT)
                dup_total++;
            if (want.status == ST_FULL)
                full_total++;
            if (got !== want)
            begin
                mismatch_total++;
                if (mismatch_total <= 10)
                begin
                    $display("%0t: mismatch: expected element %0d count %0d status %0d last %0b",
                             $time, $signed(want.element), want.count, want.status,
                             want.last);
                    $display("    got element %0d count %0d status %0d last %0b",
                             $signed(got.element), got.count, got.status, got.last);
                end
            end
        end
    endtask

    // Results are taken first: a result word never belongs to a command word
    // accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_vals.delete();
            awaited_results.delete();
            mismatch_total  = 0;
            checked_total   = 0;
            dup_total       = 0;
            full_total      = 0;
            errors          <= 0;
            awaited         <= 0;
            results_checked <= 0;
            dup_seen        <= 0;
            full_seen       <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_result_word();
            if (in_ch.valid && in_ch.ready)
                apply_set_word(in_ch.command, in_ch.value);
            errors          <= mismatch_total;
            awaited         <= awaited_results.size();
            results_checked <= checked_total;
            dup_seen        <= dup_total;
            full_seen       <= full_total;
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb
// Testbench top of the sorted integer set. It drives directed command words
// (empty report, extremes, duplicates) and then random inserts and reports
// that fill the set past its capacity, under three idling patterns, and
// gives the verdict from the checker's failure count.
// ============================================================================
module tb;
    import sisir_pkg::*;

    localparam int RANDOM_WORDS = 180;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;

    int send_idle_pct;
    int recv_idle_pct;
    int inserts_sent;
    int reports_sent;

    int set_errors;
    int set_awaited;
    int set_checked;
    int set_dups;
    int set_fulls;

    sisir_in_if  in_ch();
    sisir_out_if out_ch();

    sorted_int_set_insert_report #(
        .CAPACITY (DEF_CAPACITY)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    sorted_set_checker #(
        .CAPACITY (DEF_CAPACITY)
    ) set_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .errors          (set_errors),
        .awaited         (set_awaited),
        .results_checked (set_checked),
        .dup_seen        (set_dups),
        .full_seen       (set_fulls)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver side: ready drops at random in line with the current pattern.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one command word, idling first at random, and wait until it is taken.
    task automatic send_word(input logic cmd, input logic signed [VAL_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.value   <= v;
        if (cmd == CMD_REPORT)
            reports_sent++;
        else
            inserts_sent++;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic                    cmd;
        logic signed [VAL_W-1:0] v;
        int                      pick;

        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_INSERT;
        in_ch.value   = '0;
        out_ch.ready  = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 66;
        inserts_sent  = 0;
        reports_sent  = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: empty report, extremes, duplicates, alternating bits.
        send_word(CMD_REPORT, 32'sd0);
        send_word(CMD_INSERT, 32'sd0);
        send_word(CMD_INSERT, 32'sh8000_0000);
        send_word(CMD_INSERT, 32'sh7FFF_FFFF);
        send_word(CMD_INSERT, -32'sd1);
        send_word(CMD_INSERT, 32'sd1);
        send_word(CMD_INSERT, 32'sh7FFF_FFFF);
        send_word(CMD_INSERT, 32'sh8000_0000);
        send_word(CMD_REPORT, 32'shFFFF_FFFF);
        send_word(CMD_INSERT, 32'sh5555_5555);
        send_word(CMD_INSERT, 32'shAAAA_AAAA);
        send_word(CMD_INSERT, 32'sd0);
        send_word(CMD_REPORT, 32'sh5555_5555);

        // Random words: mostly inserts, drawn partly from a narrow range so that
        // duplicates are common and the set fills past its capacity.
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k == RANDOM_WORDS / 3) begin
                send_idle_pct = 66;
                recv_idle_pct = 13;
            end
            else if (k == 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            cmd  = ($urandom_range(99) < 15) ? CMD_REPORT : CMD_INSERT;
            pick = $urandom_range(99);
            if (pick < 40)
                v = $signed(VAL_W'($urandom_range(40))) - 32'sd20;
            else if (pick < 45)
                v = 32'sh8000_0000 + $signed(VAL_W'($urandom_range(3)));
            else if (pick < 50)
                v = 32'sh7FFF_FFFF - $signed(VAL_W'($urandom_range(3)));
            else
                v = $signed($urandom);
            send_word(cmd, v);
        end
        in_ch.valid <= 1'b0;
        @(posedge clk);

        // Drain: wait for every outstanding result word, then a few more cycles.
        while (set_awaited != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d insert and %0d report words under three idling patterns.",
                 inserts_sent, reports_sent);
        $display("Checked %0d result words: %0d duplicates and %0d dropped on a full set.",
                 set_checked, set_dups, set_fulls);
        if (set_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #5_000_000;
        $display("Run timed out with %0d result words outstanding.", set_awaited);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
